FILE: hw/rtl/sccp_pkg.sv
// ----------------------------------------------------------------------------
// sccp_pkg
// Shared widths, palette tables and the quarter-wave cosine table for the
// speed-to-cosine-palette color core.
// ----------------------------------------------------------------------------
package sccp_pkg;

    // table depth and output color width
    localparam int COS_TABLE_DEPTH = 256;
    localparam int COLOR_BITS      = 8;

    // field and datapath widths
    localparam int VEL_W   = 16;
    localparam int SPD_W   = 16;
    localparam int SQ_W    = 32;
    localparam int T_W     = 17;
    localparam int FRAC_W  = 15;
    localparam int COS_W   = 16;
    localparam int LVL_W   = 17;
    localparam int IDX_W   = $clog2(COS_TABLE_DEPTH + 1);
    localparam int NUM_CH  = 3;

    // pipeline stage counts per unit
    localparam int SPD_STAGES = 2;
    localparam int DIV_STAGES = T_W;
    localparam int CLR_STAGES = 3;
    localparam int NUM_STAGES = SPD_STAGES + DIV_STAGES + CLR_STAGES;

    // fixed values
    localparam logic [SPD_W-1:0] TOP_SPEED_RST = SPD_W'(256);
    localparam logic [T_W-1:0]   T_ONE         = T_W'(65536);
    localparam logic [LVL_W-1:0] LVL_HALF      = LVL_W'(32768);
    localparam logic [COLOR_BITS-1:0] CMAX     = {COLOR_BITS{1'b1}};

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_SPEED = 1'b0,
        CFG_PALETTE   = 1'b1
    } t_cfg_idx;

    // palette presets
    typedef enum logic [1:0] {
        PRESET_MONO     = 2'd0,
        PRESET_CHROMA   = 2'd1,
        PRESET_RED_BLUE = 2'd2,
        PRESET_PINK     = 2'd3
    } t_preset;

    typedef logic [T_W-1:0] t_phase_row [0:NUM_CH-1];
    typedef t_phase_row     t_phase_tab [0:3];
    typedef logic [NUM_CH-1:0] t_amp_tab [0:3];

    // channel phase, modulo 2*pi in units of pi/65536 (red, green, blue)
    localparam t_phase_tab PHASE_TAB = '{
        '{T_W'(0),     T_W'(0),     T_W'(0)},
        '{T_W'(65536), T_W'(32768), T_W'(0)},
        '{T_W'(65536), T_W'(98304), T_W'(0)},
        '{T_W'(32768), T_W'(65536), T_W'(124518)}
    };

    // negative amplitude per channel, bit 0 is red
    localparam t_amp_tab AMP_NEG = '{3'b111, 3'b000, 3'b000, 3'b100};

    // quarter-wave cosine table, Q1.15
    typedef logic [COS_W-1:0] t_cos_tab [0:COS_TABLE_DEPTH];
    typedef longint unsigned  t_div_tab [1:10];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam t_div_tab TAYLOR_DIV = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                        64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

    // taylor series evaluated at elaboration
    function automatic t_cos_tab build_cos_tab();
        t_cos_tab        tab;
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
            theta = (HALF_PI_Q30 * longint'(k)) / COS_TABLE_DEPTH;
            x2    = (theta * theta) >> 30;
            term  = 64'd1 << 30;
            sum   = longint'(term);
            for (int n = 1; n <= 10; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 16384) >>> 15;
            if (sum > 32768) begin
                sum = 32768;
            end
            tab[k] = COS_W'(sum);
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos_tab();

endpackage

FILE: hw/rtl/sccp_vel_if.sv
// ----------------------------------------------------------------------------
// sccp_vel_if
// Velocity channel: valid/ready handshake with signed Q8.8 components.
// ----------------------------------------------------------------------------
interface sccp_vel_if
    import sccp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;

    modport source (output valid, output vel_x, output vel_y, input ready);
    modport sink   (input valid, input vel_x, input vel_y, output ready);
endinterface

FILE: hw/rtl/sccp_rgb_if.sv
// ----------------------------------------------------------------------------
// sccp_rgb_if
// Color channel: valid/ready handshake with one RGB word.
// ----------------------------------------------------------------------------
interface sccp_rgb_if
    import sccp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: hw/rtl/sccp_speed.sv
// ----------------------------------------------------------------------------
// sccp_speed
// Squares the velocity components and the max speed, sums the squares and
// flags words whose squared-speed ratio reaches 2.0 (or whose max speed is zero).
// ----------------------------------------------------------------------------
module sccp_speed
    import sccp_pkg::*;
(
    input  logic                    i_clk,
    input  logic [SPD_STAGES-1:0]   i_en,
    input  logic signed [VEL_W-1:0] i_vel_x,
    input  logic signed [VEL_W-1:0] i_vel_y,
    input  logic [SPD_W-1:0]        i_top_speed,
    output logic [SQ_W-1:0]         o_rem,
    output logic [SQ_W-1:0]         o_dvs,
    output logic                    o_sat
);

    logic signed [SQ_W-1:0] n_vx2;
    logic signed [SQ_W-1:0] n_vy2;
    logic [SQ_W-1:0]        n_msq;
    logic [SQ_W-1:0]        r_vx2;
    logic [SQ_W-1:0]        r_vy2;
    logic [SQ_W-1:0]        r_msq;
    logic [SQ_W-1:0]        n_sum;
    logic                   n_sat;
    logic [SQ_W-1:0]        r_rem;
    logic [SQ_W-1:0]        r_dvs;
    logic                   r_sat;

    // stage 0: squares
    assign n_vx2 = i_vel_x * i_vel_x;
    assign n_vy2 = i_vel_y * i_vel_y;
    assign n_msq = SQ_W'(i_top_speed) * SQ_W'(i_top_speed);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_vx2 <= n_vx2;
            r_vy2 <= n_vy2;
            r_msq <= n_msq;
        end
    end

    // stage 1: squared speed and saturation check (quotient >= 2 or max is zero)
    assign n_sum = SQ_W'(r_vx2 + r_vy2);
    assign n_sat = ({1'b0, n_sum} >= {r_msq, 1'b0}) || (r_msq == '0);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_rem <= n_sum;
            r_dvs <= r_msq;
            r_sat <= n_sat;
        end
    end

    assign o_rem = r_rem;
    assign o_dvs = r_dvs;
    assign o_sat = r_sat;

endmodule

FILE: hw/rtl/sccp_div.sv
// ----------------------------------------------------------------------------
// sccp_div
// Pipelined restoring divider: one quotient bit per stage, giving
// floor(speed^2 * 2^16 / max^2) in 17 bits when the ratio is below 2.
// ----------------------------------------------------------------------------
module sccp_div
    import sccp_pkg::*;
(
    input  logic                  i_clk,
    input  logic [DIV_STAGES-1:0] i_en,
    input  logic [SQ_W-1:0]       i_rem,
    input  logic [SQ_W-1:0]       i_dvs,
    input  logic                  i_sat,
    output logic [T_W-1:0]        o_q,
    output logic                  o_sat
);

    logic [SQ_W-1:0] r_rem [0:DIV_STAGES-1];
    logic [SQ_W-1:0] r_dvs [0:DIV_STAGES-1];
    logic [T_W-1:0]  r_q   [0:DIV_STAGES-1];
    logic            r_sat [0:DIV_STAGES-1];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        logic [SQ_W-1:0] rem_in;
        logic [SQ_W-1:0] dvs_in;
        logic [T_W-1:0]  q_in;
        logic            sat_in;
        logic [SQ_W:0]   x;
        logic [SQ_W:0]   diff;
        logic            ge;

        // first stage takes the sum unshifted, later ones shift the remainder
        if (j == 0) begin : g_first
            assign rem_in = i_rem;
            assign dvs_in = i_dvs;
            assign q_in   = '0;
            assign sat_in = i_sat;
            assign x      = {1'b0, rem_in};
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign dvs_in = r_dvs[j-1];
            assign q_in   = r_q[j-1];
            assign sat_in = r_sat[j-1];
            assign x      = {rem_in, 1'b0};
        end

        // compare and subtract
        assign diff = x - {1'b0, dvs_in};
        assign ge   = (x >= {1'b0, dvs_in});

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j] <= ge ? diff[SQ_W-1:0] : x[SQ_W-1:0];
                r_dvs[j] <= dvs_in;
                r_q[j]   <= {q_in[T_W-2:0], ge};
                r_sat[j] <= sat_in;
            end
        end
    end

    assign o_q   = r_q[DIV_STAGES-1];
    assign o_sat = r_sat[DIV_STAGES-1];

endmodule

FILE: hw/rtl/sccp_color.sv
// ----------------------------------------------------------------------------
// sccp_color
// Clamps t, forms each channel's angle, looks up the quarter-wave cosine
// and scales 0.5*(1 + amp*cos) to the output color width.
// ----------------------------------------------------------------------------
module sccp_color
    import sccp_pkg::*;
(
    input  logic                  i_clk,
    input  logic [CLR_STAGES-1:0] i_en,
    input  logic [T_W-1:0]        i_q,
    input  logic                  i_sat,
    input  t_preset               i_preset,
    output logic [COLOR_BITS-1:0] o_red,
    output logic [COLOR_BITS-1:0] o_green,
    output logic [COLOR_BITS-1:0] o_blue
);

    localparam int PROD_W = FRAC_W + IDX_W;
    localparam int SCL_W  = LVL_W + COLOR_BITS;

    logic [T_W-1:0]        t;
    logic [IDX_W-1:0]      r_idx [0:NUM_CH-1];
    logic                  r_neg [0:NUM_CH-1];
    logic [LVL_W-1:0]      r_lvl [0:NUM_CH-1];
    logic [COLOR_BITS-1:0] r_out [0:NUM_CH-1];

    // t saturates at 1.0
    assign t = (i_sat || (i_q > T_ONE)) ? T_ONE : i_q;

    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        logic [T_W-1:0]    ang;
        logic [1:0]        quad;
        logic [PROD_W-1:0] prod;
        logic [IDX_W-1:0]  i_fwd;
        logic [IDX_W-1:0]  idx;
        logic              neg;
        logic [LVL_W-1:0]  cosv;
        logic [SCL_W-1:0]  scl;

        // stage 0: angle, table index and sign
        assign ang   = t - PHASE_TAB[i_preset][c];
        assign quad  = ang[T_W-1 -: 2];
        assign prod  = PROD_W'(ang[FRAC_W-1:0]) * PROD_W'(COS_TABLE_DEPTH);
        assign i_fwd = prod[FRAC_W +: IDX_W];
        assign idx   = quad[0] ? (IDX_W'(COS_TABLE_DEPTH) - i_fwd) : i_fwd;
        assign neg   = (quad[1] ^ quad[0]) ^ AMP_NEG[i_preset][c];

        always_ff @(posedge i_clk) begin
            if (i_en[0]) begin
                r_idx[c] <= idx;
                r_neg[c] <= neg;
            end
        end

        // stage 1: table read, level in [0, 65536]
        assign cosv = LVL_W'(COS_TAB[r_idx[c]]);

        always_ff @(posedge i_clk) begin
            if (i_en[1]) begin
                r_lvl[c] <= r_neg[c] ? (LVL_HALF - cosv) : (LVL_HALF + cosv);
            end
        end

        // stage 2: scale to color width with rounding
        assign scl = (SCL_W'(r_lvl[c]) * SCL_W'(CMAX)) + SCL_W'(32768);

        always_ff @(posedge i_clk) begin
            if (i_en[2]) begin
                r_out[c] <= scl[16 +: COLOR_BITS];
            end
        end
    end

    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

endmodule

FILE: hw/rtl/speed_to_cosine_palette_color_core.sv
// ----------------------------------------------------------------------------
// speed_to_cosine_palette_color_core
// Throughput: one word per cycle unless the output stalls; the 17-stage divider sets the depth.
// Each stage advances on its own, so bubbles close up under output stall.
// Reset (synchronous, active low) empties the pipeline, sets the top speed
// to 1.0 and the palette to mono; no clearing pass.
// ----------------------------------------------------------------------------
module speed_to_cosine_palette_color_core
    import sccp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SPD_W-1:0]     i_cfg_data,
    sccp_vel_if.sink             i_vel,
    sccp_rgb_if.source           o_rgb
);

    localparam int DIV_LO = SPD_STAGES;
    localparam int CLR_LO = SPD_STAGES + DIV_STAGES;

    logic [SPD_W-1:0]      r_top_speed;
    t_preset               r_preset;
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] load;

    logic [SQ_W-1:0]       spd_rem;
    logic [SQ_W-1:0]       spd_dvs;
    logic                  spd_sat;
    logic [T_W-1:0]        div_q;
    logic                  div_sat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_speed <= TOP_SPEED_RST;
            r_preset    <= PRESET_MONO;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TOP_SPEED: r_top_speed <= i_cfg_data;
                CFG_PALETTE:   r_preset    <= t_preset'(i_cfg_data[1:0]);
            endcase
        end
    end

    // a stage loads when it or any later stage is empty, or the output is taken
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_load
        assign load[k] = o_rgb.ready || !(&r_vld[NUM_STAGES-1:k]);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (load[k]) begin
                    r_vld[k] <= (k == 0) ? i_vel.valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign i_vel.ready = load[0];
    assign o_rgb.valid = r_vld[NUM_STAGES-1];

    // squares and saturation
    sccp_speed u_speed (
        .i_clk       (i_clk),
        .i_en        (load[SPD_STAGES-1:0]),
        .i_vel_x     (i_vel.vel_x),
        .i_vel_y     (i_vel.vel_y),
        .i_top_speed (r_top_speed),
        .o_rem       (spd_rem),
        .o_dvs       (spd_dvs),
        .o_sat       (spd_sat)
    );

    // ratio divider
    sccp_div u_div (
        .i_clk (i_clk),
        .i_en  (load[DIV_LO +: DIV_STAGES]),
        .i_rem (spd_rem),
        .i_dvs (spd_dvs),
        .i_sat (spd_sat),
        .o_q   (div_q),
        .o_sat (div_sat)
    );

    // palette lookup and scaling
    sccp_color u_color (
        .i_clk    (i_clk),
        .i_en     (load[CLR_LO +: CLR_STAGES]),
        .i_q      (div_q),
        .i_sat    (div_sat),
        .i_preset (r_preset),
        .o_red    (o_rgb.red),
        .o_green  (o_rgb.green),
        .o_blue   (o_rgb.blue)
    );

`ifndef SYNTHESIS
    // a word in the first stage moves on whenever the next stage loads
    a_first_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && load[1] |=> r_vld[1])
        else $error("word lost between stage 0 and stage 1");

    // mono preset gives a gray word when it ran through the color stages unstalled
    a_mono_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NUM_STAGES-1] && $past(load[NUM_STAGES-1], 1)
            && $past(load[NUM_STAGES-2], 2) && $past(load[NUM_STAGES-3], 3)
            && ($past(r_preset, 3) == PRESET_MONO)
        |-> (o_rgb.red == o_rgb.green) && (o_rgb.green == o_rgb.blue))
        else $error("mono palette word is not gray");
`endif

endmodule
